// File: design/utc_pkg.sv
package utc_pkg;

  typedef enum logic [1:0] {
    CLASS_ASCII = 2'd0,
    CLASS_UTF8  = 2'd1,
    CLASS_8BIT  = 2'd2
  } text_class_t;

  // Continuation byte pattern 10xxxxxx
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_MATCH = 8'h80;

  localparam logic [1:0] SEQ_LEN_TWO   = 2'd2;
  localparam logic [1:0] SEQ_LEN_THREE = 2'd3;

  typedef struct packed {
    logic [1:0] pending_continuations;
    logic [1:0] pending_total;
    logic       ascii_only;
    logic       still_valid;
    logic       decided;
  } state_t;

  localparam state_t STATE_RESET = '{
    pending_continuations: 2'd0,
    pending_total:         2'd0,
    ascii_only:            1'b1,
    still_valid:           1'b1,
    decided:               1'b0
  };

endpackage

// File: design/utc_step.sv
module utc_step (
  input  utc_pkg::state_t      state,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output utc_pkg::state_t      state_next,
  output utc_pkg::text_class_t text_class
);

  utc_pkg::state_t fail_state;
  logic            first_of_three;
  logic            is_cont;

  assign is_cont        = (data_byte & utc_pkg::CONT_MASK) == utc_pkg::CONT_MATCH;
  assign first_of_three = (state.pending_total == utc_pkg::SEQ_LEN_THREE) &&
                          (state.pending_continuations == 2'd2);

  always_comb begin
    fail_state                       = state;
    fail_state.ascii_only            = 1'b0;
    fail_state.still_valid           = 1'b0;
    fail_state.decided               = 1'b1;
    fail_state.pending_continuations = 2'd0;
  end

  always_comb begin
    state_next = state;
    if (!state.decided) begin
      if (state.pending_continuations != 2'd0) begin
        // truncated three-byte sequence: leave the final byte unchecked
        if (first_of_three && last_byte) begin
          state_next.pending_continuations = 2'd0;
        end else if (!is_cont) begin
          state_next = fail_state;
        end else begin
          state_next.pending_continuations = state.pending_continuations - 2'd1;
        end
      end else begin
        case (data_byte) inside
          [8'h01:8'h7F]: begin
            state_next = state;
          end
          [8'hC0:8'hDF]: begin
            state_next.ascii_only            = 1'b0;
            state_next.pending_continuations = 2'd1;
            state_next.pending_total         = utc_pkg::SEQ_LEN_TWO;
          end
          [8'hE0:8'hEF]: begin
            state_next.ascii_only            = 1'b0;
            state_next.pending_continuations = 2'd2;
            state_next.pending_total         = utc_pkg::SEQ_LEN_THREE;
          end
          default: begin
            // NUL, stray continuation, or four-byte lead and above
            state_next = fail_state;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (state_next.ascii_only) begin
      text_class = utc_pkg::CLASS_ASCII;
    end else if (state_next.still_valid) begin
      text_class = utc_pkg::CLASS_UTF8;
    end else begin
      text_class = utc_pkg::CLASS_8BIT;
    end
  end

endmodule

// File: design/utf8_text_classifier_core.sv
// Classifies a byte stream as 7-bit ASCII, UTF-8 without BOM (sequences of
// up to three bytes) or other 8-bit text, with one class beat per buffer,
// issued for the beat that carries last_byte. The core takes one byte per
// cycle while in_ready is high; a byte passes through the input register
// and the combinational state update, and the class is registered into the
// output register once that register is free. The output register holds a
// class while the sink stalls; bytes keep flowing until a second last byte
// has to wait behind it and in_ready drops. Classifier state returns to
// its initial values after every buffer, so buffers can follow each other
// back to back.
module utf8_text_classifier_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] text_class
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_last;
  logic                 s1_advance;
  logic                 s1_emit;
  utc_pkg::state_t      state;
  utc_pkg::state_t      state_next;
  utc_pkg::text_class_t class_next;

  utc_step u_step (
    .state      (state),
    .data_byte  (s1_byte),
    .last_byte  (s1_last),
    .state_next (state_next),
    .text_class (class_next)
  );

  // a last byte can only move on when the output register is free
  assign s1_advance = !s1_last || !out_valid || out_ready;
  assign s1_emit    = s1_valid && s1_last && s1_advance;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= utc_pkg::STATE_RESET;
    end else if (s1_valid && s1_advance) begin
      state <= s1_last ? utc_pkg::STATE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      text_class <= class_next;
    end
  end

  a_decided_is_8bit: assert property (@(posedge clk) disable iff (rst)
    state.decided |-> !state.still_valid && !state.ascii_only)
    else $error("decided state still claims ASCII or UTF-8");

  a_open_seq_not_ascii: assert property (@(posedge clk) disable iff (rst)
    state.pending_continuations != 2'd0 |-> !state.ascii_only)
    else $error("open sequence with ascii_only set");

  a_state_clears: assert property (@(posedge clk) disable iff (rst)
    s1_emit |=> state == utc_pkg::STATE_RESET)
    else $error("state not cleared after buffer end");

  a_out_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("class beat without a last byte");

endmodule

// File: sim/tb_top.sv
module tb_top;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] text_class;

  byte_beat_t           pending_bytes[$];
  utc_pkg::text_class_t expected_classes[$];
  utc_pkg::text_class_t exp_class;
  byte_beat_t           next_beat;
  logic                 in_taken = 1'b0;
  int                   send_gap = 0;
  int                   sink_stall = 0;
  int                   mismatch_count = 0;

  // classifier state tracked alongside the core
  logic [1:0] seq_left = 2'd0;
  logic [1:0] seq_len = 2'd0;
  logic       all_ascii = 1'b1;
  logic       utf8_ok = 1'b1;
  logic       verdict_fixed = 1'b0;

  utf8_text_classifier_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .text_class (text_class)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void rule_out_utf8();
    all_ascii = 1'b0;
    utf8_ok = 1'b0;
    verdict_fixed = 1'b1;
    seq_left = 2'd0;
  endfunction

  task automatic classify_byte(input logic [7:0] b, input logic last);
    logic first_of_three;
    first_of_three = (seq_len == utc_pkg::SEQ_LEN_THREE) && (seq_left == 2'd2);
    if (!verdict_fixed) begin
      if (seq_left != 2'd0) begin
        // a three-byte lead cut off after one more byte is not checked
        if (first_of_three && last) seq_left = 2'd0;
        else if ((b & utc_pkg::CONT_MASK) != utc_pkg::CONT_MATCH) rule_out_utf8();
        else seq_left = seq_left - 2'd1;
      end else if (b == 8'h00) begin
        rule_out_utf8();
      end else if (b < 8'h80) begin
      end else if (b < 8'hC0) begin
        rule_out_utf8();
      end else if (b < 8'hE0) begin
        all_ascii = 1'b0;
        seq_left = 2'd1;
        seq_len = utc_pkg::SEQ_LEN_TWO;
      end else if (b < 8'hF0) begin
        all_ascii = 1'b0;
        seq_left = 2'd2;
        seq_len = utc_pkg::SEQ_LEN_THREE;
      end else begin
        rule_out_utf8();
      end
    end
    if (last) begin
      if (all_ascii) expected_classes.push_back(utc_pkg::CLASS_ASCII);
      else if (utf8_ok) expected_classes.push_back(utc_pkg::CLASS_UTF8);
      else expected_classes.push_back(utc_pkg::CLASS_8BIT);
      seq_left = 2'd0;
      seq_len = 2'd0;
      all_ascii = 1'b1;
      utf8_ok = 1'b1;
      verdict_fixed = 1'b0;
    end
  endtask

  task automatic queue_buffer(input logic [7:0] bytes[$]);
    byte_beat_t bt;
    foreach (bytes[i]) begin
      bt.data = bytes[i];
      bt.last = (i == bytes.size() - 1);
      pending_bytes.push_back(bt);
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // kind 0: plain ASCII, 1: well-formed UTF-8, 2: UTF-8 with faults mixed in
  task automatic queue_random_buffer(input int kind);
    logic [7:0] bytes[$];
    int units;
    int r;
    int bad;
    units = $urandom_range(1, 6);
    repeat (units) begin
      r = $urandom_range(0, 99);
      if (kind == 0 || r < 35) begin
        bytes.push_back(8'($urandom_range(1, 127)));
      end else if (r < 60) begin
        bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        bytes.push_back(cont_byte());
      end else if (r < 82 || kind == 1) begin
        bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        bytes.push_back(cont_byte());
        bytes.push_back(cont_byte());
      end else begin
        bad = $urandom_range(0, 191);
        case ($urandom_range(0, 5))
          0: bytes.push_back(8'h00);
          1: bytes.push_back(cont_byte());
          2: bytes.push_back(8'($urandom_range(8'hF0, 8'hFF)));
          3: begin
            bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            bytes.push_back(8'(bad < 128 ? bad : bad + 64));
          end
          4: begin
            bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            bytes.push_back(cont_byte());
            bytes.push_back(8'(bad < 128 ? bad : bad + 64));
          end
          default: bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    // cut the tail now and then so a sequence may be left open at the end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        if (bytes.size() > 1) void'(bytes.pop_back());
      end
    end
    queue_buffer(bytes);
  endtask

  // source side: hold a beat until taken, otherwise advance or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 50 && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else begin
        next_beat = pending_bytes.pop_front();
        in_valid <= 1'b1;
        data_byte <= next_beat.data;
        last_byte <= next_beat.last;
      end
    end
  end

  // sink side: random stall bursts, none near the end
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ready <= 1'b0;
    end else if (pending_bytes.size() > 50 && $urandom_range(0, 7) == 0) begin
      sink_stall <= $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_classes.size() == 0) begin
          report_mismatch($sformatf("class beat %0d with none expected", text_class));
        end else begin
          exp_class = expected_classes.pop_front();
          if (text_class !== exp_class)
            report_mismatch($sformatf("text_class got %0d expected %0d",
                                      text_class, exp_class));
        end
      end
      if (in_valid && in_ready) classify_byte(data_byte, last_byte);
    end
  end

  initial begin
    queue_buffer('{8'h00});
    queue_buffer('{8'h01, 8'h7F});
    queue_buffer('{8'hFF});
    queue_buffer('{8'h80});
    queue_buffer('{8'hC0});
    queue_buffer('{8'hDF, 8'hBF});
    queue_buffer('{8'hEF, 8'h00});
    queue_buffer('{8'hE0, 8'h80, 8'hBF});
    queue_buffer('{8'hC3, 8'h41});
    queue_buffer('{8'hE1, 8'h80, 8'h7F});
    queue_buffer('{8'hF0, 8'hC3, 8'hA9, 8'h41});
    queue_buffer('{8'h41, 8'hE2});
    while (pending_bytes.size() < 450) begin
      case ($urandom_range(0, 9))
        0, 1: queue_random_buffer(0);
        2, 3, 4, 5, 6: queue_random_buffer(1);
        default: queue_random_buffer(2);
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_bytes.size() == 0 && in_valid == 1'b0);
    wait (expected_classes.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
